// ----- rtl/sphere_to_cube_face_map_macros.svh -----
// ----------------------------------------------------------------------------
// Sphere to cube face map: assertion macros
// Shared concurrent assertion forms for the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef SPHERE_TO_CUBE_FACE_MAP_MACROS_SVH
`define SPHERE_TO_CUBE_FACE_MAP_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define S2CF_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("s2cf: same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define S2CF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("s2cf: next-cycle check failed");

`endif

// ----- rtl/s2cf_pkg.sv -----
// ----------------------------------------------------------------------------
// Sphere to cube face map: package
// Widths, fixed-point constants, face codes and shared types.
// ----------------------------------------------------------------------------
package s2cf_pkg;

   // Default face coordinate precision
   localparam int COORD_BITS_DEF = 16;

   // Field widths
   localparam int LON_W = 17;
   localparam int LAT_W = 16;
   localparam int ANG_W = 15;   // folded angle, 0..quarter turn
   localparam int Q_W   = 31;   // Q30 magnitude up to 1.0
   localparam int OUT_W = 16;

   // Angle limits in 1/256 degree
   localparam logic signed [LON_W-1:0] LON_MAX = 17'sd46080;
   localparam logic signed [LAT_W-1:0] LAT_MAX = 16'sd23040;
   localparam logic [LON_W-2:0] HALF_TURN    = 16'd46080;
   localparam logic [LON_W-2:0] QUARTER_TURN = 16'd23040;

   // Degrees * 256 to radians in Q30 (times 2^10)
   localparam logic [26:0] RAD_Q40 = 27'd74961321;
   localparam logic [Q_W-1:0] Q30_ONE = 31'h4000_0000;

   // Horner series divisors and their reciprocals scaled by 2^34
   localparam int HORNER_STEPS = 6;
   localparam int RECIP_SHIFT = 34;
   localparam logic [7:0] HORNER_DIV [HORNER_STEPS] = '{
      8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
   localparam logic [31:0] HORNER_MUL [HORNER_STEPS] = '{
      32'((64'd1 << 34) / 156), 32'((64'd1 << 34) / 110),
      32'((64'd1 << 34) / 72),  32'((64'd1 << 34) / 42),
      32'((64'd1 << 34) / 20),  32'((64'd1 << 34) / 6)};

   // Sine unit pipeline stages: radians, square, three per series step, final product
   localparam int SIN_LAT = 3 * HORNER_STEPS + 3;

   // Face codes
   localparam logic [2:0] FACE_REAR   = 3'd0;
   localparam logic [2:0] FACE_FRONT  = 3'd1;
   localparam logic [2:0] FACE_EAST   = 3'd2;
   localparam logic [2:0] FACE_WEST   = 3'd3;
   localparam logic [2:0] FACE_TOP    = 3'd4;
   localparam logic [2:0] FACE_BOTTOM = 3'd5;

   typedef logic [2:0]        face_type;
   typedef logic [Q_W-1:0]    q30_type;
   typedef logic signed [31:0] vec_type;
   typedef logic [OUT_W-1:0]  coord_type;

   // Sign information that rides alongside the sine units
   typedef struct packed {
      logic lat_neg;   // latitude below zero
      logic lon_pos;   // longitude above zero
      logic lon_far;   // |longitude| beyond a quarter turn
   } side_type;

endpackage

// ----- rtl/s2cf_chan_if.sv -----
// ----------------------------------------------------------------------------
// Sphere to cube face map: channel interfaces
// Valid/ready channels for angle words in and face words out.
// ----------------------------------------------------------------------------
interface s2cf_req_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] longitude;
   logic signed [15:0] latitude;

   modport source (output valid, output longitude, output latitude, input ready);
   modport sink   (input valid, input longitude, input latitude, output ready);
endinterface

interface s2cf_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  face;
   logic [15:0] face_u;
   logic [15:0] face_v;

   modport source (output valid, output face, output face_u, output face_v, input ready);
   modport sink   (input valid, input face, input face_u, input face_v, output ready);
endinterface

// ----- rtl/s2cf_sin_quarter.sv -----
// ----------------------------------------------------------------------------
// Sphere to cube face map: quarter-wave sine
// Pipelined Q30 sine of 0..90 degrees by a degree-13 Horner series.
// ----------------------------------------------------------------------------
module s2cf_sin_quarter
   import s2cf_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [ANG_W-1:0] angle,
   output q30_type          sine
);

   logic [41:0] rad_prod;
   logic [61:0] sq_prod;
   logic [61:0] fin_prod;
   logic [31:0] fin_sh;

   logic [Q_W-1:0] r0_ff;
   logic [Q_W-1:0] r1_ff;
   logic [31:0]    r2_1_ff;
   q30_type        sine_ff;

   // Per series step: product stage (a), reciprocal stage (b), fix-up stage (c)
   logic [Q_W-1:0] ra_ff  [HORNER_STEPS];
   logic [31:0]    r2a_ff [HORNER_STEPS];
   logic [31:0]    pa_ff  [HORNER_STEPS];
   logic [Q_W-1:0] rb_ff  [HORNER_STEPS];
   logic [31:0]    r2b_ff [HORNER_STEPS];
   logic [31:0]    pb_ff  [HORNER_STEPS];
   logic [29:0]    q0b_ff [HORNER_STEPS];
   logic [Q_W-1:0] rc_ff  [HORNER_STEPS];
   logic [31:0]    r2c_ff [HORNER_STEPS];
   logic [Q_W-1:0] hc_ff  [HORNER_STEPS];

   // Convert to radians, then square
   assign rad_prod = 42'(angle) * 42'(RAD_Q40);
   assign sq_prod  = 62'(r0_ff) * 62'(r0_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         r0_ff   <= rad_prod[40:10];
         r1_ff   <= r0_ff;
         r2_1_ff <= sq_prod[61:30];
      end
   end

   for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_step
      logic [Q_W-1:0] r_src;
      logic [31:0]    r2_src;
      logic [Q_W-1:0] h_src;
      logic [62:0]    prod_a;
      logic [63:0]    prod_b;
      logic [31:0]    chk_c;
      logic [31:0]    rem_c;
      logic [Q_W-1:0] quo_c;

      if (i == 0) begin : g_first
         assign r_src  = r1_ff;
         assign r2_src = r2_1_ff;
         assign h_src  = Q30_ONE;
      end else begin : g_next
         assign r_src  = rc_ff[i-1];
         assign r2_src = r2c_ff[i-1];
         assign h_src  = hc_ff[i-1];
      end

      // Multiply by the running term, divide by the constant via reciprocal
      assign prod_a = 63'(r2_src) * 63'(h_src);
      assign prod_b = 64'(pa_ff[i]) * 64'(HORNER_MUL[i]);

      // Correct the reciprocal estimate by at most one, then subtract from one
      assign chk_c = 32'(38'(q0b_ff[i]) * 38'(HORNER_DIV[i]));
      assign rem_c = pb_ff[i] - chk_c;
      assign quo_c = 31'(q0b_ff[i]) + 31'(rem_c >= 32'(HORNER_DIV[i]));

      always_ff @(posedge clock) begin
         if (en) begin
            ra_ff[i]  <= r_src;
            r2a_ff[i] <= r2_src;
            pa_ff[i]  <= prod_a[61:30];
            rb_ff[i]  <= ra_ff[i];
            r2b_ff[i] <= r2a_ff[i];
            pb_ff[i]  <= pa_ff[i];
            q0b_ff[i] <= prod_b[63:RECIP_SHIFT];
            rc_ff[i]  <= rb_ff[i];
            r2c_ff[i] <= r2b_ff[i];
            hc_ff[i]  <= Q30_ONE - quo_c;
         end
      end
   end

   // Final product, clamped to one
   assign fin_prod = 62'(rc_ff[HORNER_STEPS-1]) * 62'(hc_ff[HORNER_STEPS-1]);
   assign fin_sh   = fin_prod[61:30];

   always_ff @(posedge clock) begin
      if (en) begin
         sine_ff <= (fin_sh > {1'b0, Q30_ONE}) ? Q30_ONE : fin_sh[Q_W-1:0];
      end
   end

   assign sine = sine_ff;

endmodule

// ----- rtl/s2cf_coord_div.sv -----
// ----------------------------------------------------------------------------
// Sphere to cube face map: face coordinate divider
// Pipelined restoring division (c + m) * 2^COORD_BITS / (2m), one bit a stage.
// ----------------------------------------------------------------------------
module s2cf_coord_div
   import s2cf_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
)(
   input  logic              clock,
   input  logic              en,
   input  vec_type           coord,
   input  q30_type           mag,
   output logic [COORD_BITS:0] quot
);

   logic [31:0]       rem_ff [COORD_BITS];
   logic [31:0]       den_ff [COORD_BITS];
   logic [COORD_BITS:0] quo_ff [COORD_BITS+1];

   logic signed [32:0] sum0;
   logic [31:0]        num0;
   logic [31:0]        den0;
   logic               bit0;

   // Offset the coordinate into 0..2m and take the integer quotient bit
   assign sum0 = 33'(coord) + 33'($signed({2'b00, mag}));
   assign num0 = sum0[31:0];
   assign den0 = {mag, 1'b0};
   assign bit0 = (num0 >= den0);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= bit0 ? (num0 - den0) : num0;
         den_ff[0] <= den0;
         quo_ff[0] <= (COORD_BITS+1)'(bit0);
      end
   end

   // One fraction bit per stage
   for (genvar j = 1; j <= COORD_BITS; j++) begin : g_bit
      logic [32:0] sh;
      logic        qb;

      assign sh = {rem_ff[j-1], 1'b0};
      assign qb = (sh >= {1'b0, den_ff[j-1]});

      if (j < COORD_BITS) begin : g_mid
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= qb ? 32'(sh - {1'b0, den_ff[j-1]}) : sh[31:0];
               den_ff[j] <= den_ff[j-1];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[j] <= {quo_ff[j-1][COORD_BITS-1:0], qb};
         end
      end
   end

   assign quot = quo_ff[COORD_BITS];

endmodule

// ----- rtl/sphere_to_cube_face_map.sv -----
// ----------------------------------------------------------------------------
// Sphere to cube face map: top level
// Longitude/latitude to cube face and face coordinates, fully pipelined.
// ----------------------------------------------------------------------------
//  Channel    Dir  Payload                         Handshake
//  req_chan   in   longitude[16:0], latitude[15:0] valid/ready
//  rsp_chan   out  face[2:0], face_u, face_v       valid/ready
//
//  One word enters per cycle while the output word is not held; the depth of
//  the pipeline is set by the sine series and the bit-per-stage coordinate
//  divider.
//  Reset clears the valid bits only; no clearing pass. req_chan.ready is low
//  while reset is high.
//  A stalled output word freezes the whole pipeline; req_chan.ready follows.
// ----------------------------------------------------------------------------
`include "sphere_to_cube_face_map_macros.svh"

module sphere_to_cube_face_map
   import s2cf_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
)(
   input  logic       clock,
   input  logic       reset,
   s2cf_req_if.sink   req_chan,
   s2cf_rsp_if.source rsp_chan
);

   localparam int DIV_LAT = COORD_BITS + 1;
   localparam int MUL_POS = SIN_LAT + 1;
   localparam int SEL_POS = SIN_LAT + 2;
   localparam int DIV_POS = SEL_POS + DIV_LAT;
   localparam logic [COORD_BITS-1:0] COORD_HALF = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic en;

   // Valid bits travel with the data
   logic [DIV_POS:0] vld_ff;
   logic             rsp_valid_ff;

   // Clamp and fold stage
   logic signed [LON_W-1:0] lon_c;
   logic signed [LAT_W-1:0] lat_c;
   logic [LON_W-2:0]        lon_abs;
   logic [LON_W-2:0]        lat_abs;
   logic [ANG_W-1:0] b_slon_ff, b_clon_ff, b_slat_ff, b_clat_ff;
   side_type         side_ff [SIN_LAT+1];
   side_type         side_in;

   // Sine outputs
   q30_type s_slon, s_clon, s_slat, s_clat;

   // Vector stage
   logic [61:0] px_prod, pz_prod;
   q30_type     xm_ff, ym_ff, zm_ff;
   logic        xn_ff, yn_ff, zn_ff;

   // Selection stage
   vec_type  sx, sy, sz;
   logic     x_pos, y_pos, z_pos;
   face_type face_in;
   vec_type  cu_in, cv_in;
   q30_type  m_in;
   face_type face_ff;
   vec_type  cu_ff, cv_ff;
   q30_type  m_ff;
   vec_type  m_sig;
   logic     u_in_range, v_in_range;
   logic     vec_in_unit;
   logic     u_over;

   // Divider and output
   logic [COORD_BITS:0]   quot_u, quot_v;
   face_type              face_d_ff [DIV_LAT];
   logic [DIV_LAT-1:0]    zero_d_ff;
   logic [COORD_BITS-1:0] u_sat, v_sat;
   face_type              face_out_ff;
   coord_type             face_u_ff, face_v_ff;

   // Advance everything unless the output word is held
   assign en = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[DIV_POS-1:0], req_chan.valid};
         rsp_valid_ff <= vld_ff[DIV_POS];
      end
   end

   // Clamp the angles and fold them into the first quadrant
   always_comb begin
      if (req_chan.longitude > LON_MAX)       lon_c = LON_MAX;
      else if (req_chan.longitude < -LON_MAX) lon_c = -LON_MAX;
      else                                    lon_c = req_chan.longitude;
      if (req_chan.latitude > LAT_MAX)        lat_c = LAT_MAX;
      else if (req_chan.latitude < -LAT_MAX)  lat_c = -LAT_MAX;
      else                                    lat_c = req_chan.latitude;
      lon_abs = (lon_c < 0) ? 16'(-lon_c) : 16'(lon_c);
      lat_abs = (lat_c < 0) ? 16'(-lat_c) : 16'(lat_c);
      side_in.lat_neg = (lat_c < 0);
      side_in.lon_pos = (lon_c > 0);
      side_in.lon_far = (lon_abs > QUARTER_TURN);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_slon_ff <= side_in.lon_far ? 15'(HALF_TURN - lon_abs) : 15'(lon_abs);
         b_clon_ff <= side_in.lon_far ? 15'(lon_abs - QUARTER_TURN)
                                      : 15'(QUARTER_TURN - lon_abs);
         b_slat_ff <= 15'(lat_abs);
         b_clat_ff <= 15'(QUARTER_TURN - lat_abs);
         side_ff[0] <= side_in;
         for (int k = 1; k <= SIN_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Four sine pipelines
   s2cf_sin_quarter u_sin_slon (.clock(clock), .en(en), .angle(b_slon_ff), .sine(s_slon));
   s2cf_sin_quarter u_sin_clon (.clock(clock), .en(en), .angle(b_clon_ff), .sine(s_clon));
   s2cf_sin_quarter u_sin_slat (.clock(clock), .en(en), .angle(b_slat_ff), .sine(s_slat));
   s2cf_sin_quarter u_sin_clat (.clock(clock), .en(en), .angle(b_clat_ff), .sine(s_clat));

   // Form the vector as sign and magnitude
   assign px_prod = 62'(s_clat) * 62'(s_slon);
   assign pz_prod = 62'(s_clat) * 62'(s_clon);

   always_ff @(posedge clock) begin
      if (en) begin
         xm_ff <= px_prod[60:30];
         zm_ff <= pz_prod[60:30];
         ym_ff <= s_slat;
         xn_ff <= side_ff[SIN_LAT].lon_pos;
         zn_ff <= !side_ff[SIN_LAT].lon_far;
         yn_ff <= side_ff[SIN_LAT].lat_neg;
      end
   end

   // Pick the dominant axis and the face coordinates
   always_comb begin
      sx = xn_ff ? -$signed({1'b0, xm_ff}) : $signed({1'b0, xm_ff});
      sy = yn_ff ? -$signed({1'b0, ym_ff}) : $signed({1'b0, ym_ff});
      sz = zn_ff ? -$signed({1'b0, zm_ff}) : $signed({1'b0, zm_ff});
      x_pos = !xn_ff && (xm_ff != '0);
      y_pos = !yn_ff && (ym_ff != '0);
      z_pos = !zn_ff && (zm_ff != '0);
      if (xm_ff >= ym_ff && xm_ff >= zm_ff) begin
         m_in  = xm_ff;
         cv_in = -sy;
         if (x_pos) begin
            face_in = FACE_REAR;
            cu_in   = -sz;
         end else begin
            face_in = FACE_FRONT;
            cu_in   = sz;
         end
      end else if (zm_ff >= ym_ff) begin
         m_in  = zm_ff;
         cv_in = -sy;
         if (z_pos) begin
            face_in = FACE_EAST;
            cu_in   = sx;
         end else begin
            face_in = FACE_WEST;
            cu_in   = -sx;
         end
      end else begin
         m_in  = ym_ff;
         cu_in = sz;
         if (y_pos) begin
            face_in = FACE_TOP;
            cv_in   = -sx;
         end else begin
            face_in = FACE_BOTTOM;
            cv_in   = sx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         face_ff <= face_in;
         cu_ff   <= cu_in;
         cv_ff   <= cv_in;
         m_ff    <= m_in;
      end
   end

   // Divide both coordinates by twice the dominant magnitude
   s2cf_coord_div #(.COORD_BITS(COORD_BITS)) u_div_u (
      .clock(clock), .en(en), .coord(cu_ff), .mag(m_ff), .quot(quot_u));
   s2cf_coord_div #(.COORD_BITS(COORD_BITS)) u_div_v (
      .clock(clock), .en(en), .coord(cv_ff), .mag(m_ff), .quot(quot_v));

   // Carry the face code and the zero-magnitude case past the divider
   always_ff @(posedge clock) begin
      if (en) begin
         face_d_ff[0] <= face_ff;
         zero_d_ff[0] <= (m_ff == '0);
         for (int k = 1; k < DIV_LAT; k++) begin
            face_d_ff[k] <= face_d_ff[k-1];
            zero_d_ff[k] <= zero_d_ff[k-1];
         end
      end
   end

   // Saturate one to all ones and hold the output word
   assign u_sat = quot_u[COORD_BITS] ? '1 : quot_u[COORD_BITS-1:0];
   assign v_sat = quot_v[COORD_BITS] ? '1 : quot_v[COORD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         face_out_ff <= face_d_ff[DIV_LAT-1];
         face_u_ff   <= zero_d_ff[DIV_LAT-1] ? 16'(COORD_HALF) : 16'(u_sat);
         face_v_ff   <= zero_d_ff[DIV_LAT-1] ? 16'(COORD_HALF) : 16'(v_sat);
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.face   = face_out_ff;
   assign rsp_chan.face_u = face_u_ff;
   assign rsp_chan.face_v = face_v_ff;

   // Terms for the checks below
   assign m_sig       = $signed({1'b0, m_ff});
   assign u_in_range  = (cu_ff <= m_sig) && (cu_ff >= -m_sig);
   assign v_in_range  = (cv_ff <= m_sig) && (cv_ff >= -m_sig);
   assign vec_in_unit = (xm_ff <= Q30_ONE) && (ym_ff <= Q30_ONE) && (zm_ff <= Q30_ONE);
   assign u_over      = quot_u[COORD_BITS] && (quot_u[COORD_BITS-1:0] != '0);

   `S2CF_ASSERT_IMPL(a_sel_mag_nonzero, clock, reset, vld_ff[SEL_POS], m_ff != '0)
   `S2CF_ASSERT_IMPL(a_sel_coord_bound, clock, reset, vld_ff[SEL_POS], u_in_range && v_in_range)
   `S2CF_ASSERT_IMPL(a_div_range, clock, reset, vld_ff[DIV_POS], !u_over)
   `S2CF_ASSERT_IMPL(a_vec_unit, clock, reset, vld_ff[MUL_POS], vec_in_unit)
   `S2CF_ASSERT_NEXT(a_pipe_freeze, clock, reset, !en, $stable(vld_ff) && $stable(quot_u))
   `S2CF_ASSERT_IMPL(a_face_code, clock, reset, rsp_valid_ff, face_out_ff <= FACE_BOTTOM)

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Sphere to cube face map: testbench
// Drives longitude/latitude words with random idle and stall bursts, predicts
// the cube face and face coordinates for each accepted word, and checks every
// face word in order. Includes one long receiver hold-off to back up the pipe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
   import s2cf_pkg::*;
();

   typedef struct {
      face_type  face;
      coord_type u;
      coord_type v;
   } face_word_type;

   // Predicts face words from angle words and checks the block's output
   class face_scoreboard;
      face_word_type pending_q[$];
      int mismatches = 0;
      int checked = 0;
      int face_seen[6];

      // Q30 sine over 0..quarter turn, Taylor series in Horner form
      function automatic longint unsigned sine_quarter(longint unsigned b);
         longint unsigned divs[6] = '{156, 110, 72, 42, 20, 6};
         longint unsigned one = longint'(Q30_ONE);
         longint unsigned r, r2, h, s;
         if (b > QUARTER_TURN) b = QUARTER_TURN;
         r = (b * longint'(RAD_Q40)) >> 10;
         r2 = (r * r) >> 30;
         h = one;
         for (int k = 0; k < 6; k++) h = one - ((r2 * h) >> 30) / divs[k];
         s = (r * h) >> 30;
         return (s > one) ? one : s;
      endfunction

      function automatic longint sine_of(longint a);
         longint b = (a < 0) ? -a : a;
         longint s;
         if (b > QUARTER_TURN) b = longint'(HALF_TURN) - b;
         s = longint'(sine_quarter(b));
         return (a < 0) ? -s : s;
      endfunction

      function automatic longint cosine_of(longint a);
         longint b = (a < 0) ? -a : a;
         if (b <= QUARTER_TURN) return longint'(sine_quarter(longint'(QUARTER_TURN) - b));
         return -longint'(sine_quarter(b - longint'(QUARTER_TURN)));
      endfunction

      function automatic longint magnitude(longint a);
         return (a < 0) ? -a : a;
      endfunction

      // Product of Q30 values on magnitudes, truncated, then signed
      function automatic longint q30_mul(longint a, longint b);
         longint p = (magnitude(a) * magnitude(b)) >> 30;
         return ((a < 0) != (b < 0)) ? -p : p;
      endfunction

      // Map c in -m..m onto 0..1 as a 16-bit fraction, saturating at all ones
      function automatic coord_type to_face_coord(longint c, longint m);
         longint unsigned num, q;
         if (m == 0) return coord_type'(1 << 15);
         num = longint'(c + m) << 16;
         q = num / longint'(2 * m);
         if (q > 65535) q = 65535;
         return coord_type'(q);
      endfunction

      function automatic face_word_type predict_face(longint lon, longint lat);
         face_word_type w;
         longint y, cl, x, z, mx, my, mz, m, cu, cv;
         if (lon > LON_MAX) lon = LON_MAX;
         if (lon < -longint'(LON_MAX)) lon = -longint'(LON_MAX);
         if (lat > LAT_MAX) lat = LAT_MAX;
         if (lat < -longint'(LAT_MAX)) lat = -longint'(LAT_MAX);
         y = sine_of(lat);
         cl = cosine_of(lat);
         x = q30_mul(cl, -sine_of(lon));
         z = -q30_mul(cl, cosine_of(lon));
         mx = magnitude(x); my = magnitude(y); mz = magnitude(z);
         if (mx >= my && mx >= mz) begin
            m = mx;
            if (x > 0) begin w.face = FACE_REAR; cu = -z; cv = -y; end
            else begin w.face = FACE_FRONT; cu = z; cv = -y; end
         end else if (mz >= my) begin
            m = mz;
            if (z > 0) begin w.face = FACE_EAST; cu = x; cv = -y; end
            else begin w.face = FACE_WEST; cu = -x; cv = -y; end
         end else begin
            m = my;
            if (y > 0) begin w.face = FACE_TOP; cu = z; cv = -x; end
            else begin w.face = FACE_BOTTOM; cu = z; cv = x; end
         end
         w.u = to_face_coord(cu, m);
         w.v = to_face_coord(cv, m);
         return w;
      endfunction

      function void note_angles(logic signed [16:0] lon, logic signed [15:0] lat);
         pending_q.push_back(predict_face(longint'(lon), longint'(lat)));
      endfunction

      function void check_face(face_type face, coord_type u, coord_type v);
         face_word_type w;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected face word: face %0d u %0d v %0d", face, u, v);
            return;
         end
         w = pending_q.pop_front();
         checked++;
         if (w.face < 6) face_seen[w.face]++;
         if (face !== w.face || u !== w.u || v !== w.v) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch at word %0d: expected face %0d u %0d v %0d, got %0d %0d %0d",
                        checked, w.face, w.u, w.v, face, u, v);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   s2cf_req_if req ();
   s2cf_rsp_if rsp ();
   face_scoreboard board = new();

   int cycles = 0;
   int hold_cycles = 0;
   bit calm = 1'b0;
   int sent = 0;

   sphere_to_cube_face_map DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on total run length
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   // Count down the long receiver hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
   end

   // Check face words and stall the output side in random bursts
   int stall_left = 0;
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) board.check_face(rsp.face, rsp.face_u, rsp.face_v);
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // Offer one angle word, with an optional idle burst first
   task automatic send_angles(int lon, int lat);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.longitude <= 17'(lon);
      req.latitude <= 16'(lat);
      do @(posedge clock); while (!req.ready);
      board.note_angles(17'(lon), 16'(lat));
      sent++;
   endtask

   task automatic send_random();
      int pick = $urandom_range(0, 9);
      if (pick < 7)
         send_angles($urandom_range(0, 92160) - 46080, $urandom_range(0, 46080) - 23040);
      else if (pick < 9)
         send_angles(int'($signed(17'($urandom))), int'($signed(16'($urandom))));
      else
         // hover around quarter turns and the poles
         send_angles(($urandom_range(0, 1) ? 23040 : -23040) + $urandom_range(0, 64) - 32,
                     ($urandom_range(0, 1) ? 23040 : -23040) + $urandom_range(0, 64) - 32);
   endtask

   initial begin
      int directed[][2] = '{
         '{0, 0}, '{46080, 0}, '{-46080, 0}, '{23040, 0}, '{-23040, 0},
         '{0, 23040}, '{0, -23040}, '{11520, 0}, '{-11520, 0}, '{34560, 0},
         '{0, 11520}, '{23040, 11520}, '{46080, -11520}, '{-65536, 0},
         '{65535, 0}, '{0, -32768}, '{0, 32767}, '{-65536, -32768},
         '{65535, 32767}, '{5760, 9040}, '{-40320, -9040}, '{1, 1}, '{-1, -1}};
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.longitude <= '0;
      req.latitude <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners: poles, quarter turns, saturation, face edges
      foreach (directed[i]) send_angles(directed[i][0], directed[i][1]);

      // Random words; a long output hold-off backs up the pipeline
      for (int n = 0; n < 2000; n++) begin
         if (n == 400) hold_cycles = 300;
         if (n == 1700) calm = 1'b1;
         send_random();
      end
      req.valid <= 1'b0;

      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("sent %0d angle words, checked %0d face words", sent, board.checked);
      $display("faces rear %0d front %0d east %0d west %0d top %0d bottom %0d",
               board.face_seen[0], board.face_seen[1], board.face_seen[2],
               board.face_seen[3], board.face_seen[4], board.face_seen[5]);
      if (board.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- sphere_to_cube_face_map.f -----
+incdir+rtl
rtl/s2cf_pkg.sv
rtl/s2cf_chan_if.sv
rtl/s2cf_sin_quarter.sv
rtl/s2cf_coord_div.sv
rtl/sphere_to_cube_face_map.sv
sim/testbench.sv
